@@ rtl/tetra_pkg.sv @@
package tetra_pkg;

  localparam int COORD_BITS    = 10;
  localparam int SUM_BITS      = COORD_BITS + 2;
  localparam int CROSS_BITS    = 2 * COORD_BITS + 1;
  localparam int DET_BITS      = 3 * COORD_BITS + 2;
  localparam int DET_LO_BITS   = DET_BITS / 2;
  localparam int DET_HI_BITS   = DET_BITS - DET_LO_BITS;
  localparam int WGT_BITS      = 2 * COORD_BITS + 4;
  localparam int LO_PROD_BITS  = WGT_BITS + DET_LO_BITS + 1;
  localparam int HI_PROD_BITS  = WGT_BITS + DET_HI_BITS;
  localparam int OUT_BITS      = 63;
  localparam int ENTRIES       = 6;

  localparam int IXX = 0;
  localparam int IYY = 1;
  localparam int IZZ = 2;
  localparam int PXY = 3;
  localparam int PXZ = 4;
  localparam int PYZ = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   csum_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic signed [DET_BITS-1:0]   det_t;
  typedef logic signed [WGT_BITS-1:0]   wgt_t;
  typedef logic signed [OUT_BITS-1:0]   tensor_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
  } mul_ctl_t;

endpackage

@@ rtl/tetra_if.sv @@
interface tetra_in_if import tetra_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t ax;
  coord_t ay;
  coord_t az;
  coord_t bx;
  coord_t by;
  coord_t bz;
  coord_t cx;
  coord_t cy;
  coord_t cz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tetra_out_if import tetra_pkg::*; ();
  logic    valid;
  logic    ready;
  tensor_t ixx;
  tensor_t iyy;
  tensor_t izz;
  tensor_t pxy;
  tensor_t pxz;
  tensor_t pyz;

  modport source (output valid, ixx, iyy, izz, pxy, pxz, pyz, input ready);
  modport sink (input valid, ixx, iyy, izz, pxy, pxz, pyz, output ready);
endinterface

@@ rtl/tetra_split_mul.sv @@
module tetra_split_mul import tetra_pkg::*; (
  input  logic     clk,
  input  mul_ctl_t ctl,
  input  wgt_t     wgt,
  input  det_t     det,
  output tensor_t  prod
);

  logic signed [DET_LO_BITS:0]     det_lo;
  logic signed [DET_HI_BITS-1:0]   det_hi;
  logic signed [LO_PROD_BITS-1:0]  lo;
  logic signed [HI_PROD_BITS-1:0]  hi;

  assign det_lo = $signed({1'b0, det[DET_LO_BITS-1:0]});
  assign det_hi = $signed(det[DET_BITS-1:DET_LO_BITS]);

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      lo <= LO_PROD_BITS'(wgt) * LO_PROD_BITS'(det_lo);
      hi <= HI_PROD_BITS'(wgt) * HI_PROD_BITS'(det_hi);
    end
    if (ctl.ld_sum) begin
      prod <= (OUT_BITS'(hi) <<< DET_LO_BITS) + OUT_BITS'(lo);
    end
  end

endmodule

@@ rtl/tetrahedron_inertia_tensor.sv @@
// Inertia tensor of a tetrahedron with its fourth corner at the origin. Each item carries
// three corners as signed coordinates; each result carries the six distinct tensor entries,
// times the signed volume and scaled by 120, as exact 63-bit integers. The block takes one
// item per clock cycle while the output is not stalled. It has four
// register stages: coordinate sums and cross products, then the determinant and the six
// weights, then the weight-by-determinant product cut into two partial products, then their
// sum. Each stage holds its item while the next one is full, so a stall at the output backs
// up one stage at a time and the input keeps accepting while any stage is empty.
module tetrahedron_inertia_tensor import tetra_pkg::*; (
  input logic         clk,
  input logic         rst,
  tetra_in_if.sink    tet,
  tetra_out_if.source tensor
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  coord_t x1, y1, z1, x2, y2, z2, x3, y3, z3;
  csum_t  sx, sy, sz;
  cross_t c1, c2, c3;

  det_t   det2;
  wgt_t   wgt2 [ENTRIES];
  wgt_t   tx, ty, tz, oxy, oxz, oyz;
  det_t   det_next;

  tensor_t  prod [ENTRIES];
  mul_ctl_t ctl;

  assign rdy4 = !v4 || tensor.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign tet.ready = rdy1;
  assign tensor.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= tet.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && tet.valid) begin
      x1 <= tet.ax;
      y1 <= tet.ay;
      z1 <= tet.az;
      x2 <= tet.bx;
      y2 <= tet.by;
      z2 <= tet.bz;
      x3 <= tet.cx;
      y3 <= tet.cy;
      z3 <= tet.cz;
      sx <= SUM_BITS'(tet.ax) + SUM_BITS'(tet.bx) + SUM_BITS'(tet.cx);
      sy <= SUM_BITS'(tet.ay) + SUM_BITS'(tet.by) + SUM_BITS'(tet.cy);
      sz <= SUM_BITS'(tet.az) + SUM_BITS'(tet.bz) + SUM_BITS'(tet.cz);
      c1 <= CROSS_BITS'(tet.by) * CROSS_BITS'(tet.cz) - CROSS_BITS'(tet.bz) * CROSS_BITS'(tet.cy);
      c2 <= CROSS_BITS'(tet.bz) * CROSS_BITS'(tet.cx) - CROSS_BITS'(tet.bx) * CROSS_BITS'(tet.cz);
      c3 <= CROSS_BITS'(tet.bx) * CROSS_BITS'(tet.cy) - CROSS_BITS'(tet.by) * CROSS_BITS'(tet.cx);
    end
  end

  // Twice a diagonal sum equals the squared coordinate total plus the sum of squares, and
  // each off-diagonal weight equals the product of the totals plus the sum of matched products.
  always_comb begin
    tx = WGT_BITS'(sx) * WGT_BITS'(sx) + WGT_BITS'(x1) * WGT_BITS'(x1)
       + WGT_BITS'(x2) * WGT_BITS'(x2) + WGT_BITS'(x3) * WGT_BITS'(x3);
    ty = WGT_BITS'(sy) * WGT_BITS'(sy) + WGT_BITS'(y1) * WGT_BITS'(y1)
       + WGT_BITS'(y2) * WGT_BITS'(y2) + WGT_BITS'(y3) * WGT_BITS'(y3);
    tz = WGT_BITS'(sz) * WGT_BITS'(sz) + WGT_BITS'(z1) * WGT_BITS'(z1)
       + WGT_BITS'(z2) * WGT_BITS'(z2) + WGT_BITS'(z3) * WGT_BITS'(z3);
    oxy = WGT_BITS'(sx) * WGT_BITS'(sy) + WGT_BITS'(x1) * WGT_BITS'(y1)
        + WGT_BITS'(x2) * WGT_BITS'(y2) + WGT_BITS'(x3) * WGT_BITS'(y3);
    oxz = WGT_BITS'(sx) * WGT_BITS'(sz) + WGT_BITS'(x1) * WGT_BITS'(z1)
        + WGT_BITS'(x2) * WGT_BITS'(z2) + WGT_BITS'(x3) * WGT_BITS'(z3);
    oyz = WGT_BITS'(sy) * WGT_BITS'(sz) + WGT_BITS'(y1) * WGT_BITS'(z1)
        + WGT_BITS'(y2) * WGT_BITS'(z2) + WGT_BITS'(y3) * WGT_BITS'(z3);
    det_next = DET_BITS'(x1) * DET_BITS'(c1) + DET_BITS'(y1) * DET_BITS'(c2)
             + DET_BITS'(z1) * DET_BITS'(c3);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      det2      <= det_next;
      wgt2[IXX] <= ty + tz;
      wgt2[IYY] <= tx + tz;
      wgt2[IZZ] <= tx + ty;
      wgt2[PXY] <= oxy;
      wgt2[PXZ] <= oxz;
      wgt2[PYZ] <= oyz;
    end
  end

  assign ctl.ld_mul = rdy3 && v2;
  assign ctl.ld_sum = rdy4 && v3;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    tetra_split_mul u_mul (
      .clk  (clk),
      .ctl  (ctl),
      .wgt  (wgt2[i]),
      .det  (det2),
      .prod (prod[i])
    );
  end

  assign tensor.ixx = prod[IXX];
  assign tensor.iyy = prod[IYY];
  assign tensor.izz = prod[IZZ];
  assign tensor.pxy = prod[PXY];
  assign tensor.pxz = prod[PXZ];
  assign tensor.pyz = prod[PYZ];

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    tet.valid && tet.ready |=> v1)
    else $error("Accepted item did not enter the first stage.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy3 |=> v3)
    else $error("Stalled item was lost from the multiply stage.");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    tensor.valid && tensor.ready && !v3 |=> !tensor.valid)
    else $error("Result appeared without an item behind it.");

  a_diag_nonneg: assert property (@(posedge clk) disable iff (rst)
    v2 |-> !wgt2[IXX][WGT_BITS-1] && !wgt2[IYY][WGT_BITS-1] && !wgt2[IZZ][WGT_BITS-1])
    else $error("Diagonal weight is negative.");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tetra_pkg::*;

  localparam int     N_RANDOM    = 1150;
  localparam int     IDLE_PCT    = 31;
  localparam int     STUCK_LIMIT = 2000;
  localparam int     TAIL_CYCLES = 20;
  localparam int     HOLD_CYCLES = 120;
  localparam coord_t CMAX        = 10'sd511;
  localparam coord_t CMIN        = -10'sd512;

  typedef struct {
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
  } tet_item_t;

  typedef struct {
    tensor_t ixx, iyy, izz;
    tensor_t pxy, pxz, pyz;
  } tensor_item_t;

  logic clk;
  logic rst;

  tetra_in_if  tet_if ();
  tetra_out_if tensor_if ();

  tetrahedron_inertia_tensor u_top (
    .clk    (clk),
    .rst    (rst),
    .tet    (tet_if),
    .tensor (tensor_if)
  );

  tet_item_t    pending_tets[$];
  tensor_item_t want_tensors[$];

  int n_total;
  int n_sent;
  int n_taken;
  int n_results;
  int n_err;
  int stuck_cycles;
  bit in_taken;
  bit drained;
  bit hold_done;
  int hold_left;

  function automatic longint diag_moment(longint p, longint q, longint r);
    return p * (p + q + r) + q * (q + r) + r * r;
  endfunction

  function automatic longint cross_moment(longint p1, longint p2, longint p3,
                                          longint q1, longint q2, longint q3);
    longint same;
    longint mixed;
    same  = p1 * q1 + p2 * q2 + p3 * q3;
    mixed = p1 * (q2 + q3) + p2 * (q1 + q3) + p3 * (q1 + q2);
    return 2 * same + mixed;
  endfunction

  function automatic tensor_item_t inertia_of(tet_item_t t);
    longint x1, y1, z1, x2, y2, z2, x3, y3, z3;
    longint det, sx, sy, sz;
    tensor_item_t r;
    x1 = t.ax; y1 = t.ay; z1 = t.az;
    x2 = t.bx; y2 = t.by; z2 = t.bz;
    x3 = t.cx; y3 = t.cy; z3 = t.cz;
    det = x1 * (y2 * z3 - z2 * y3) + y1 * (z2 * x3 - x2 * z3) + z1 * (x2 * y3 - y2 * x3);
    sx = diag_moment(x1, x2, x3);
    sy = diag_moment(y1, y2, y3);
    sz = diag_moment(z1, z2, z3);
    r.ixx = tensor_t'(2 * (sy + sz) * det);
    r.iyy = tensor_t'(2 * (sx + sz) * det);
    r.izz = tensor_t'(2 * (sx + sy) * det);
    r.pxy = tensor_t'(cross_moment(x1, x2, x3, y1, y2, y3) * det);
    r.pxz = tensor_t'(cross_moment(x1, x2, x3, z1, z2, z3) * det);
    r.pyz = tensor_t'(cross_moment(y1, y2, y3, z1, z2, z3) * det);
    return r;
  endfunction

  function automatic coord_t pick_coord(int unsigned mode);
    case (mode)
      0: return coord_t'($urandom_range(1023));
      1: return coord_t'($urandom_range(15) - 8);
      default: begin
        case ($urandom_range(5))
          0: return CMIN;
          1: return CMIN + 1;
          2: return -10'sd1;
          3: return 10'sd0;
          4: return 10'sd1;
          default: return CMAX;
        endcase
      end
    endcase
  endfunction

  task automatic push_tet(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                          coord_t bz, coord_t cx, coord_t cy, coord_t cz);
    tet_item_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    pending_tets.push_back(t);
  endtask

  task automatic push_random_tet();
    tet_item_t   t;
    int unsigned kind;
    int unsigned mode;
    kind = $urandom_range(99);
    mode = (kind < 55) ? 0 : (kind < 70) ? 1 : (kind < 85) ? 2 : 0;
    t.ax = pick_coord(mode); t.ay = pick_coord(mode); t.az = pick_coord(mode);
    t.bx = pick_coord(mode); t.by = pick_coord(mode); t.bz = pick_coord(mode);
    t.cx = pick_coord(mode); t.cy = pick_coord(mode); t.cz = pick_coord(mode);
    if (kind >= 85 && kind < 95) begin
      case ($urandom_range(2))
        0: begin t.cx = t.bx; t.cy = t.by; t.cz = t.bz; end
        1: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
        default: begin t.ax = 0; t.ay = 0; t.az = 0; end
      endcase
    end else if (kind >= 95) begin
      t.ax = pick_coord(2);
      t.cz = pick_coord(2);
    end
    pending_tets.push_back(t);
  endtask

  task automatic check_entry(string name, tensor_t want, tensor_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    tet_if.valid    = 1'b0;
    tet_if.ax       = '0;
    tet_if.ay       = '0;
    tet_if.az       = '0;
    tet_if.bx       = '0;
    tet_if.by       = '0;
    tet_if.bz       = '0;
    tet_if.cx       = '0;
    tet_if.cy       = '0;
    tet_if.cz       = '0;
    tensor_if.ready = 1'b0;
  end

  always @(negedge clk) begin : driver
    tet_item_t t;
    if (rst) begin
      tet_if.valid <= 1'b0;
    end else if (!tet_if.valid || in_taken) begin
      if (n_sent == 700 && !drained) begin
        // Let the pipeline run dry once before sending more.
        if (want_tensors.size() == 0) drained = 1'b1;
        tet_if.valid <= 1'b0;
      end else if (pending_tets.size() > 0 &&
                   ((n_sent >= 300 && n_sent < 500) || $urandom_range(99) >= IDLE_PCT)) begin
        t = pending_tets.pop_front();
        tet_if.ax    <= t.ax;
        tet_if.ay    <= t.ay;
        tet_if.az    <= t.az;
        tet_if.bx    <= t.bx;
        tet_if.by    <= t.by;
        tet_if.bz    <= t.bz;
        tet_if.cx    <= t.cx;
        tet_if.cy    <= t.cy;
        tet_if.cz    <= t.cz;
        tet_if.valid <= 1'b1;
        n_sent++;
      end else begin
        tet_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      tensor_if.ready <= 1'b0;
    end else begin
      if (!hold_done && n_taken >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        tensor_if.ready <= 1'b0;
      end else if (n_results >= 400 && n_results < 650) begin
        tensor_if.ready <= 1'b1;
      end else begin
        tensor_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : monitor
    tet_item_t    t;
    tensor_item_t want;
    bit           in_acc;
    bit           out_acc;
    if (rst) begin
      in_taken     <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      in_acc  = tet_if.valid && tet_if.ready;
      out_acc = tensor_if.valid && tensor_if.ready;
      in_taken <= in_acc;
      if (in_acc) begin
        t.ax = tet_if.ax; t.ay = tet_if.ay; t.az = tet_if.az;
        t.bx = tet_if.bx; t.by = tet_if.by; t.bz = tet_if.bz;
        t.cx = tet_if.cx; t.cy = tet_if.cy; t.cz = tet_if.cz;
        want_tensors.push_back(inertia_of(t));
        n_taken++;
      end
      if (out_acc) begin
        n_results++;
        if (want_tensors.size() == 0) begin
          $error("result with no item pending: ixx %0d", tensor_if.ixx);
          n_err++;
        end else begin
          want = want_tensors.pop_front();
          check_entry("ixx", want.ixx, tensor_if.ixx);
          check_entry("iyy", want.iyy, tensor_if.iyy);
          check_entry("izz", want.izz, tensor_if.izz);
          check_entry("pxy", want.pxy, tensor_if.pxy);
          check_entry("pxz", want.pxz, tensor_if.pxz);
          check_entry("pyz", want.pyz, tensor_if.pyz);
        end
      end
      stuck_cycles <= (in_acc || out_acc) ? 0 : stuck_cycles + 1;
    end
  end

  initial begin : main
    rst = 1'b1;

    push_tet(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_tet(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    push_tet(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    push_tet(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX);
    push_tet(0, 0, CMAX, 0, CMAX, 0, CMAX, 0, 0);
    push_tet(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN);
    push_tet(CMIN, 0, 0, 0, 0, CMIN, 0, CMIN, 0);
    push_tet(1, 0, 0, 0, 1, 0, 0, 0, 1);
    push_tet(-1, 0, 0, 0, 0, -1, 0, -1, 0);
    push_tet(CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN);
    push_tet(CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX);
    push_tet(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    push_tet(CMAX, 0, CMIN, CMIN, CMAX, 0, 0, CMIN, CMAX);
    push_tet(1, 2, 3, 2, 4, 6, 5, -7, 9);
    push_tet(10, -20, 30, -7, 8, 9, 3, -12, 39);
    push_tet(100, 200, 300, 0, 0, 0, -5, 6, 7);
    push_tet(341, -342, 341, -342, 341, -342, 341, 341, -342);
    push_tet(-342, 341, -342, 341, -342, 341, -342, -342, 341);
    push_tet(7, -3, 2, -4, 9, -6, 5, 1, -8);
    push_tet(-4, 9, -6, 7, -3, 2, 5, 1, -8);
    repeat (N_RANDOM) push_random_tet();
    n_total = pending_tets.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!((n_taken == n_total && want_tensors.size() == 0) ||
             stuck_cycles >= STUCK_LIMIT))
      @(negedge clk);

    if (stuck_cycles >= STUCK_LIMIT) begin
      $error("no progress for %0d cycles, %0d results outstanding",
             STUCK_LIMIT, want_tensors.size());
      n_err++;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (want_tensors.size() != 0) begin
        $error("%0d results never arrived", want_tensors.size());
        n_err++;
      end
    end

    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ tetrahedron_inertia_tensor.f @@
rtl/tetra_pkg.sv
rtl/tetra_if.sv
rtl/tetra_split_mul.sv
rtl/tetrahedron_inertia_tensor.sv
dv/tb_top.sv
